### rtl/nhtl_pkg.sv
`default_nettype none

package nhtl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] DJB_SEED = 32'd5381;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_BYTE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [9:0]  load_index;
        logic [31:0] load_line;
        logic [31:0] load_offset;
        logic [31:0] load_sum_key;
        logic [31:0] load_djb_key;
        logic [7:0]  name_byte;
        logic        last_byte;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  match_index;
        logic [31:0] match_line;
        logic [31:0] match_offset;
    } out_t;

    typedef struct packed {
        logic [31:0] line;
        logic [31:0] offset;
        logic [31:0] sum_key;
        logic [31:0] djb_key;
    } entry_t;

    typedef struct packed {
        logic             is_search;
        logic [IDX_W-1:0] index;
        entry_t           entry;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/nhtl_front.sv
`default_nettype none

module nhtl_front
    import nhtl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      push_valid,
    input  wire logic push_ready,
    output cmd_t      push_cmd
);

    logic [31:0] djb_reg;
    logic [31:0] djb_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [15:0] len_reg;
    logic [15:0] len_next;
    logic [31:0] djb_upd;
    logic [15:0] sum_upd;
    logic [15:0] len_upd;
    logic        is_byte;
    logic        fire;

    assign in_ready   = push_ready;
    assign fire       = in_valid && in_ready;
    assign is_byte    = (in_data.mode == MODE_BYTE);
    assign push_valid = in_valid && (!is_byte || in_data.last_byte);

    assign djb_upd = (djb_reg << 5) + djb_reg + {24'd0, in_data.name_byte};
    assign sum_upd = sum_reg + {8'd0, in_data.name_byte};
    assign len_upd = len_reg + 16'd1;

    always_comb
    begin
        push_cmd.is_search = is_byte;
        push_cmd.index     = in_data.load_index[IDX_W-1:0];
        if (is_byte)
        begin
            push_cmd.entry.line    = '0;
            push_cmd.entry.offset  = '0;
            push_cmd.entry.sum_key = {len_upd, sum_upd};
            push_cmd.entry.djb_key = djb_upd;
        end
        else
        begin
            push_cmd.entry.line    = in_data.load_line;
            push_cmd.entry.offset  = in_data.load_offset;
            push_cmd.entry.sum_key = in_data.load_sum_key;
            push_cmd.entry.djb_key = in_data.load_djb_key;
        end
    end

    always_comb
    begin
        djb_next = djb_reg;
        sum_next = sum_reg;
        len_next = len_reg;
        if (fire && is_byte)
        begin
            if (in_data.last_byte)
            begin
                djb_next = DJB_SEED;
                sum_next = '0;
                len_next = '0;
            end
            else
            begin
                djb_next = djb_upd;
                sum_next = sum_upd;
                len_next = len_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            djb_reg <= DJB_SEED;
            sum_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            djb_reg <= djb_next;
            sum_reg <= sum_next;
            len_reg <= len_next;
        end
    end

endmodule

`default_nettype wire

### rtl/nhtl_cmd_queue.sv
`default_nettype none

module nhtl_cmd_queue
    import nhtl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/nhtl_back.sv
`default_nettype none

module nhtl_back
    import nhtl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] entry_count,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire cmd_t             pop_cmd,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_t                  out_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_BREQ = 7'b0000010,
        ST_BCMP = 7'b0000100,
        ST_LREQ = 7'b0001000,
        ST_LCMP = 7'b0010000,
        ST_RREQ = 7'b0100000,
        ST_RCMP = 7'b1000000
    } state_t;

    entry_t mem [TABLE_DEPTH];

    state_t           state_reg;
    state_t           state_next;
    logic [31:0]      djb_reg;
    logic [31:0]      djb_next;
    logic [31:0]      sum_reg;
    logic [31:0]      sum_next;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] lo_next;
    logic [CNT_W-1:0] hix_reg;
    logic [CNT_W-1:0] hix_next;
    logic [IDX_W-1:0] pmid_reg;
    logic [IDX_W-1:0] pmid_next;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] k_next;
    out_t             res_reg;
    out_t             res_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    entry_t           rd_data_reg;

    logic [CNT_W-1:0] count_eff;
    logic [CNT_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic             key_eq;
    logic             sum_eq;
    logic [CNT_W-1:0] lo_upd;
    logic [CNT_W-1:0] hix_upd;

    assign count_eff = (entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entry_count;
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hix_reg} - 1'b1;
    assign mid       = mid_sum[IDX_W:1];
    assign key_eq    = (rd_data_reg.djb_key == djb_reg);
    assign sum_eq    = (rd_data_reg.sum_key == sum_reg);
    assign lo_upd    = (rd_data_reg.djb_key > djb_reg) ? lo_reg : ({1'b0, pmid_reg} + 1'b1);
    assign hix_upd   = (rd_data_reg.djb_key > djb_reg) ? {1'b0, pmid_reg} : hix_reg;

    assign pop_ready = (state_reg == ST_IDLE) && (!pop_cmd.is_search || !res_valid_reg);
    assign wr_en     = pop_valid && pop_ready && !pop_cmd.is_search;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        djb_next       = djb_reg;
        sum_next       = sum_reg;
        lo_next        = lo_reg;
        hix_next       = hix_reg;
        pmid_next      = pmid_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !out_ready;
        rd_en          = 1'b0;
        rd_addr        = k_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && pop_ready && pop_cmd.is_search)
                begin
                    djb_next = pop_cmd.entry.djb_key;
                    sum_next = pop_cmd.entry.sum_key;
                    lo_next  = '0;
                    hix_next = count_eff;
                    if (count_eff == '0)
                    begin
                        res_next       = '0;
                        res_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_BREQ;
                    end
                end
            end
            ST_BREQ:
            begin
                rd_en      = 1'b1;
                rd_addr    = mid;
                pmid_next  = mid;
                state_next = ST_BCMP;
            end
            ST_BCMP:
            begin
                if (key_eq)
                begin
                    if (sum_eq)
                    begin
                        res_next.found        = 1'b1;
                        res_next.match_index  = pmid_reg;
                        res_next.match_line   = rd_data_reg.line;
                        res_next.match_offset = rd_data_reg.offset;
                        res_valid_next        = 1'b1;
                        state_next            = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = {1'b0, pmid_reg};
                        state_next = ST_LREQ;
                    end
                end
                else
                begin
                    lo_next  = lo_upd;
                    hix_next = hix_upd;
                    if (lo_upd < hix_upd)
                    begin
                        state_next = ST_BREQ;
                    end
                    else
                    begin
                        res_next       = '0;
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_LREQ:
            begin
                if (k_reg == '0)
                begin
                    k_next     = {1'b0, pmid_reg} + 1'b1;
                    state_next = ST_RREQ;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(k_reg - 1'b1);
                    k_next     = k_reg - 1'b1;
                    state_next = ST_LCMP;
                end
            end
            ST_LCMP:
            begin
                if (!key_eq)
                begin
                    k_next     = {1'b0, pmid_reg} + 1'b1;
                    state_next = ST_RREQ;
                end
                else if (sum_eq)
                begin
                    res_next.found        = 1'b1;
                    res_next.match_index  = k_reg[IDX_W-1:0];
                    res_next.match_line   = rd_data_reg.line;
                    res_next.match_offset = rd_data_reg.offset;
                    res_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LREQ;
                end
            end
            ST_RREQ:
            begin
                if (k_reg >= count_eff)
                begin
                    res_next       = '0;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = k_reg[IDX_W-1:0];
                    state_next = ST_RCMP;
                end
            end
            ST_RCMP:
            begin
                if (!key_eq)
                begin
                    res_next       = '0;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (sum_eq)
                begin
                    res_next.found        = 1'b1;
                    res_next.match_index  = k_reg[IDX_W-1:0];
                    res_next.match_line   = rd_data_reg.line;
                    res_next.match_offset = rd_data_reg.offset;
                    res_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_RREQ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        djb_reg  <= djb_next;
        sum_reg  <= sum_next;
        lo_reg   <= lo_next;
        hix_reg  <= hix_next;
        pmid_reg <= pmid_next;
        k_reg    <= k_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pop_cmd.index] <= pop_cmd.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/name_hash_table_lookup_unit.sv
`default_nettype none

// Name lookup over a table of 1024 entries sorted by djb2 key, then by the
// length/byte-sum key. Load items write one entry each, and name bytes fold into
// the running keys at one transfer per cycle while the command queue has room;
// the byte marked last starts a search and yields one result, while other items
// yield none. Loads and last bytes pass through a two-entry command queue to a
// search engine built around a single read port of the entry memory with
// registered read data. A search runs a binary search for the djb2 key with at
// most floor(log2(effective entry_count)) + 1 probes, then reads the neighbor
// entries in the run of equal djb2 keys, first below and then above the probe,
// until the sum key matches; a side scan also stops at an end of the searched
// range.
// A finished result waits in an output register while the front keeps accepting
// items into the queue. The table has no reset and no clearing pass; a search
// must only reach slots that were loaded. The user must write the entry_count
// register only while the block is idle; the block itself does not enforce it.

module name_hash_table_lookup_unit
    import nhtl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_t              in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_t                  out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    logic [CNT_W-1:0] entry_count_reg;
    logic             push_valid;
    logic             push_ready;
    cmd_t             push_cmd;
    logic             pop_valid;
    logic             pop_ready;
    cmd_t             pop_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    nhtl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    nhtl_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    nhtl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_count (entry_count_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_cmd     (pop_cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import nhtl_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 32;

    localparam int NAME_RANDOM = 0;
    localparam int NAME_ZEROS  = 1;
    localparam int NAME_ONES   = 2;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    in_t              in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_t             out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;

    // Mirror of the block's state, advanced at every accepted input transfer.
    entry_t           table_mirror [TABLE_DEPTH];
    logic [31:0]      mirror_djb   = DJB_SEED;
    logic [15:0]      mirror_sum   = '0;
    logic [15:0]      mirror_len   = '0;
    logic [CNT_W-1:0] mirror_count = '0;

    in_t  items_to_send[$];
    out_t expected_matches[$];

    // Table contents as planned by the stimulus, and the names it knows.
    entry_t     rows[$];
    int         table_count;
    logic [7:0] name_pool[$];
    int         name_head[$];
    int         name_size[$];
    int         phase_names[$];

    bit idle_enable   = 1'b1;
    bit hold_off_req  = 1'b0;
    int mismatch_count = 0;
    int send_gap;
    int stall_left;
    int hold_left;
    int quiet_cycles = 0;

    name_hash_table_lookup_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] djb_step(input logic [31:0] h, input logic [7:0] b);
        return (h << 5) + h + {24'd0, b};
    endfunction

    function automatic out_t find_entry(input logic [31:0] djb, input logic [31:0] skey);
        out_t res;
        int   span;
        int   lo;
        int   hi;
        int   mid;
        int   k;
        int   hit;
        bit   probed;
        res    = '0;
        hit    = -1;
        probed = 1'b0;
        mid    = 0;
        span   = (int'(mirror_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(mirror_count);
        lo     = 0;
        hi     = span - 1;
        while (lo <= hi && !probed)
        begin
            mid = (lo + hi) / 2;
            if (table_mirror[mid].djb_key == djb)
                probed = 1'b1;
            else if (table_mirror[mid].djb_key > djb)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        if (probed)
        begin
            if (table_mirror[mid].sum_key == skey)
                hit = mid;
            for (k = mid - 1; hit < 0 && k >= 0 && table_mirror[k].djb_key == djb; k--)
                if (table_mirror[k].sum_key == skey)
                    hit = k;
            for (k = mid + 1; hit < 0 && k < span && table_mirror[k].djb_key == djb; k++)
                if (table_mirror[k].sum_key == skey)
                    hit = k;
        end
        if (hit >= 0)
        begin
            res.found        = 1'b1;
            res.match_index  = 10'(hit);
            res.match_line   = table_mirror[hit].line;
            res.match_offset = table_mirror[hit].offset;
        end
        return res;
    endfunction

    function automatic void absorb_item(input in_t it);
        if (it.mode == MODE_LOAD)
        begin
            table_mirror[it.load_index].line    = it.load_line;
            table_mirror[it.load_index].offset  = it.load_offset;
            table_mirror[it.load_index].sum_key = it.load_sum_key;
            table_mirror[it.load_index].djb_key = it.load_djb_key;
            return;
        end
        mirror_djb = djb_step(mirror_djb, it.name_byte);
        mirror_sum = mirror_sum + {8'd0, it.name_byte};
        mirror_len = mirror_len + 16'd1;
        if (it.last_byte)
        begin
            expected_matches.push_back(find_entry(mirror_djb, {mirror_len, mirror_sum}));
            mirror_djb = DJB_SEED;
            mirror_sum = '0;
            mirror_len = '0;
        end
    endfunction

    function automatic void check_match(input out_t got);
        out_t want;
        if (expected_matches.size() == 0)
        begin
            $error("Result transfer with no lookup outstanding: %h", got);
            mismatch_count++;
            return;
        end
        want = expected_matches.pop_front();
        if (got.found !== want.found)
        begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatch_count++;
        end
        if (got.match_index !== want.match_index)
        begin
            $error("match_index: expected %0d, got %0d", want.match_index, got.match_index);
            mismatch_count++;
        end
        if (got.match_line !== want.match_line)
        begin
            $error("match_line: expected %h, got %h", want.match_line, got.match_line);
            mismatch_count++;
        end
        if (got.match_offset !== want.match_offset)
        begin
            $error("match_offset: expected %h, got %h", want.match_offset, got.match_offset);
            mismatch_count++;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_enable || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_item(in_data);
            if (in_valid && !in_ready)
                ;
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (items_to_send.size() != 0)
            begin
                in_data  <= items_to_send.pop_front();
                in_valid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_match(out_data);
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left <= HOLD_OFF_CYCLES;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic in_t random_item();
        in_t it;
        it.mode         = 1'($urandom_range(0, 1));
        it.load_index   = 10'($urandom_range(0, TABLE_DEPTH - 1));
        it.load_line    = pick_word();
        it.load_offset  = pick_word();
        it.load_sum_key = pick_word();
        it.load_djb_key = pick_word();
        it.name_byte    = 8'($urandom_range(0, 255));
        it.last_byte    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_t load_item(input int slot, input entry_t e);
        in_t it;
        it              = random_item();
        it.mode         = MODE_LOAD;
        it.load_index   = 10'(slot);
        it.load_line    = e.line;
        it.load_offset  = e.offset;
        it.load_sum_key = e.sum_key;
        it.load_djb_key = e.djb_key;
        return it;
    endfunction

    function automatic in_t byte_item(input logic [7:0] b, input logic last);
        in_t it;
        it           = random_item();
        it.mode      = MODE_BYTE;
        it.name_byte = b;
        it.last_byte = last;
        return it;
    endfunction

    function automatic entry_t make_entry(input logic [31:0] djb, input logic [31:0] skey);
        entry_t e;
        e.line    = pick_word();
        e.offset  = pick_word();
        e.sum_key = skey;
        e.djb_key = djb;
        return e;
    endfunction

    function automatic void insert_row(input entry_t e);
        int pos;
        pos = 0;
        while (pos < rows.size()
               && {rows[pos].djb_key, rows[pos].sum_key} <= {e.djb_key, e.sum_key})
            pos++;
        rows.insert(pos, e);
    endfunction

    function automatic int new_name(input int len, input int style);
        int k;
        name_head.push_back(name_pool.size());
        name_size.push_back(len);
        for (k = 0; k < len; k++)
        begin
            case (style)
                NAME_ZEROS: name_pool.push_back(8'h00);
                NAME_ONES:  name_pool.push_back(8'hFF);
                default:    name_pool.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        return name_head.size() - 1;
    endfunction

    function automatic int random_name();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return new_name($urandom_range(1, 6), NAME_RANDOM);
        return new_name($urandom_range(7, 16), NAME_RANDOM);
    endfunction

    function automatic void keys_of(input int id, output logic [31:0] djb,
                                    output logic [31:0] skey);
        logic [15:0] sum;
        int          k;
        djb = DJB_SEED;
        sum = '0;
        for (k = 0; k < name_size[id]; k++)
        begin
            djb = djb_step(djb, name_pool[name_head[id] + k]);
            sum = sum + {8'd0, name_pool[name_head[id] + k]};
        end
        skey = {16'(name_size[id]), sum};
    endfunction

    // A load between name bytes: either a slot above the searched range or a
    // rewrite of a live entry that keeps its keys, so the table stays sorted.
    task automatic push_stray_load();
        entry_t e;
        int     slot;
        if (table_count < TABLE_DEPTH && $urandom_range(0, 1) == 1)
        begin
            slot = $urandom_range(table_count, TABLE_DEPTH - 1);
            e    = make_entry(pick_word(), pick_word());
        end
        else if (table_count > 0)
        begin
            slot       = $urandom_range(0, table_count - 1);
            e          = make_entry(rows[slot].djb_key, rows[slot].sum_key);
            rows[slot] = e;
        end
        else
            return;
        items_to_send.push_back(load_item(slot, e));
    endtask

    task automatic push_name(input int id, input bit noisy);
        int k;
        for (k = 0; k < name_size[id]; k++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                push_stray_load();
            items_to_send.push_back(byte_item(name_pool[name_head[id] + k],
                                              k == name_size[id] - 1));
        end
    endtask

    task automatic drain();
        while (items_to_send.size() != 0 || in_valid || expected_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        mirror_count = CNT_W'(value);
        table_count  = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
        cfg_valid <= 1'b0;
    endtask

    task automatic build_table(input int n);
        logic [31:0] djb;
        logic [31:0] skey;
        logic [31:0] d;
        int          id;
        int          r;
        int          j;
        int          k;
        int          tmp;
        int          ndecoy;
        int          order[$];
        rows.delete();
        phase_names.delete();
        while (rows.size() < n)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                id = random_name();
                phase_names.push_back(id);
                keys_of(id, djb, skey);
                if (r != 0)
                    insert_row(make_entry(djb, skey));
                if (r == 1)
                    insert_row(make_entry(djb, skey));
                ndecoy = (r < 3) ? $urandom_range(1, 3) : 0;
                for (j = 0; j < ndecoy; j++)
                begin
                    d = 32'($urandom_range(1, 300));
                    insert_row(make_entry(djb, j[0] ? skey + d : skey - d));
                end
            end
            else
                insert_row(make_entry(pick_word(), pick_word()));
        end
        rows = rows[0:n-1];
        for (k = 0; k < n; k++)
            order.push_back(k);
        for (k = n - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < n; k++)
            items_to_send.push_back(load_item(order[k], rows[order[k]]));
    endtask

    task automatic run_queries(input int queries, input bit squeeze);
        int j;
        int r;
        int id;
        @(negedge clk);
        for (j = 0; j < queries; j++)
        begin
            r = $urandom_range(0, 99);
            if (r < 65 && phase_names.size() != 0)
                id = phase_names[$urandom_range(0, phase_names.size() - 1)];
            else if (r < 90)
                id = random_name();
            else
                id = new_name(1, (r < 95) ? NAME_ZEROS : NAME_ONES);
            push_name(id, 1'b1);
        end
        if (squeeze)
            hold_off_req = 1'b1;
        drain();
    endtask

    task automatic run_phase(input int n, input int count, input int queries,
                             input bit squeeze);
        idle_enable = squeeze ? 1'b0 : ($urandom_range(0, 3) != 0);
        @(negedge clk);
        build_table(n);
        drain();
        write_count(count);
        run_queries(queries, squeeze);
    endtask

    task automatic run_directed();
        logic [31:0] djb;
        logic [31:0] skey;
        entry_t      top;
        int          id_a;
        int          id_b;
        int          id_c;
        int          id_d;
        int          k;
        @(negedge clk);
        id_a = new_name(1, NAME_ZEROS);
        id_b = new_name(2, NAME_ONES);
        id_c = new_name(3, NAME_RANDOM);
        id_d = new_name(2, NAME_ZEROS);
        push_name(id_a, 1'b0);
        rows.delete();
        keys_of(id_a, djb, skey);
        insert_row(make_entry(djb, skey));
        keys_of(id_b, djb, skey);
        insert_row(make_entry(djb, skey - 1));
        insert_row(make_entry(djb, skey));
        insert_row(make_entry(djb, skey + 1));
        keys_of(id_d, djb, skey);
        insert_row(make_entry(djb, skey - 2));
        insert_row(make_entry(djb, skey + 2));
        top.line    = '1;
        top.offset  = '0;
        top.sum_key = '1;
        top.djb_key = '1;
        insert_row(top);
        for (k = rows.size() - 1; k >= 0; k--)
            items_to_send.push_back(load_item(k, rows[k]));
        push_name(id_a, 1'b0);
        drain();
        write_count(rows.size());
        @(negedge clk);
        push_name(id_a, 1'b0);
        push_name(id_b, 1'b0);
        push_name(id_c, 1'b0);
        push_name(id_d, 1'b0);
        top = make_entry('1, '1);
        items_to_send.push_back(byte_item(8'hFF, 1'b0));
        items_to_send.push_back(load_item(rows.size() - 1, top));
        items_to_send.push_back(byte_item(8'hFF, 1'b1));
        drain();
    endtask

    // A count above the depth searches the whole table. Only the slots on the
    // probe path toward the top end and the last slot are loaded, with keys that
    // climb along the path, so the search and the side scans reach no other slot.
    task automatic run_clamp();
        logic [31:0] djb;
        logic [31:0] skey;
        int          id;
        int          k;
        int          lo;
        int          slot;
        @(negedge clk);
        do
        begin
            id = new_name(3, NAME_RANDOM);
            keys_of(id, djb, skey);
        end
        while (djb < 32'd16);
        lo = 0;
        for (k = 0; k < 9; k++)
        begin
            slot = (lo + TABLE_DEPTH - 1) / 2;
            items_to_send.push_back(load_item(slot, make_entry(32'(k), pick_word())));
            lo = slot + 1;
        end
        items_to_send.push_back(load_item(TABLE_DEPTH - 2, make_entry(djb, skey + 1)));
        items_to_send.push_back(load_item(TABLE_DEPTH - 1, make_entry(djb, skey + 2)));
        drain();
        write_count(2047);
        @(negedge clk);
        push_name(id, 1'b0);
        items_to_send.push_back(load_item(TABLE_DEPTH - 1, make_entry(djb, skey)));
        push_name(id, 1'b0);
        drain();
    endtask

    function automatic int small_count(input int n);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
    endfunction

    initial
    begin
        int p;
        int n;
        table_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_clamp();
        for (p = 0; p < 6; p++)
        begin
            n = $urandom_range(2, 24);
            run_phase(n, small_count(n), (p == 2) ? 24 : 10, p == 2);
        end
        run_phase(1, 1, 8, 1'b0);
        write_count(0);
        run_queries(6, 1'b0);
        for (p = 0; p < 2; p++)
        begin
            n = $urandom_range(2, 24);
            run_phase(n, small_count(n), 10, 1'b0);
        end
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
